FILE: hdl/splr_pkg.sv
`default_nettype none

package splr_pkg;

  // Instruction field codes
  localparam logic [31:0] ADVSIMD_MASK  = 32'h9F3E0C00;
  localparam logic [31:0] CNT_MATCH     = 32'h0E200800;
  localparam logic [31:0] ACROSS_MATCH  = 32'h0E300800;

  localparam logic [4:0]  FMOV_CLASS    = 5'h1E;
  localparam logic [5:0]  FMOV_ZERO_OP  = 6'h00;
  localparam logic [1:0]  FMOV_SCALAR   = 2'b00;

  localparam logic [4:0]  OP5_CNT       = 5'h05;
  localparam logic [4:0]  OP5_ADDLV     = 5'h03;
  localparam logic [4:0]  OP5_ADDV      = 5'h1B;

  localparam logic [2:0]  OPC_TO_GPR    = 3'd6;
  localparam logic [2:0]  OPC_FROM_GPR  = 3'd7;

  localparam logic [1:0]  RMODE_LOW     = 2'd0;
  localparam logic [1:0]  RMODE_UPPER   = 2'd1;

  localparam logic [1:0]  FTYPE_S       = 2'd0;
  localparam logic [1:0]  FTYPE_D       = 2'd1;
  localparam logic [1:0]  FTYPE_Q       = 2'd2;

  localparam logic [1:0]  SIZE_B        = 2'd0;
  localparam logic [1:0]  SIZE_H        = 2'd1;
  localparam logic [1:0]  SIZE_S        = 2'd2;
  localparam logic [1:0]  SIZE_D        = 2'd3;

  // Vector file write request
  typedef struct packed {
    logic        lo_we;
    logic        hi_we;
    logic [4:0]  idx;
    logic [63:0] lo;
    logic [63:0] hi;
  } splr_vwr_t;

  // One result word
  typedef struct packed {
    logic        gpr_write;
    logic [4:0]  gpr_index;
    logic [63:0] gpr_data;
    logic        undefined_insn;
  } splr_res_t;

endpackage

`default_nettype wire

FILE: hdl/simd_popcount_lane_reduce_unit.sv
`default_nettype none
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_tvalid/tready   | tdata: instruction[31:0], general_value[95:32]
// out_    | output    | out_tvalid/tready  | tdata: gpr_index, gpr_data; tuser: flags
//
// One instruction per cycle while the result is not stalled; each word goes from
// stage 1 to the result register. Stage 1 registers the word, reads the vector file
// and decodes; the result register and the vector file write are loaded together on advance.
// Reset clears all 32 vector registers at once and empties both stages.
// A stalled result holds stage 1; input is taken while stage 1 is free to advance.

module simd_popcount_lane_reduce_unit
  import splr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // [31:0] instruction, [95:32] general_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [4:0] gpr_index, [68:5] gpr_data, [71:69] zero
  output logic [1:0]       out_tuser   // [0] gpr_write, [1] undefined_insn
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] s1_instr_r;
  logic [63:0] s1_gv_r;
  logic        out_valid_r, out_valid_nxt;
  splr_res_t   out_res_r;

  logic        adv, in_acc;
  logic [63:0] vlo, vhi;
  splr_res_t   res;
  splr_vwr_t   exec_wr, vrf_wr;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  splr_vrf u_vrf (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (s1_instr_r[9:5]),
    .rd_lo  (vlo),
    .rd_hi  (vhi),
    .wr     (vrf_wr)
  );

  splr_exec u_exec (
    .instr (s1_instr_r),
    .gv    (s1_gv_r),
    .vlo   (vlo),
    .vhi   (vhi),
    .res   (res),
    .wr    (exec_wr)
  );

  // Commit to the file only when the word moves into the result register
  always_comb begin
    vrf_wr = exec_wr;
    vrf_wr.lo_we = exec_wr.lo_we && s1_valid_r && adv;
    vrf_wr.hi_we = exec_wr.hi_we && s1_valid_r && adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_instr_r <= in_tdata[31:0];
      s1_gv_r    <= in_tdata[95:32];
    end
    if (adv && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.gpr_data, out_res_r.gpr_index};
  assign out_tuser  = {out_res_r.undefined_insn, out_res_r.gpr_write};

  a_undef_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.undefined_insn) |-> !out_res_r.gpr_write)
    else $error("undefined result carries a register write");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.gpr_write) |-> (out_res_r.gpr_index == 5'd0
      && out_res_r.gpr_data == 64'd0))
    else $error("gpr fields not zero without gpr_write");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv) |=> out_valid_r)
    else $error("stage 1 word lost on advance");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |-> (!in_tready && !vrf_wr.lo_we && !vrf_wr.hi_we))
    else $error("stalled word accepted input or wrote the file");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: hdl/splr_vrf.sv
`default_nettype none

module splr_vrf
  import splr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [4:0]  rd_idx,
  output logic [63:0]      rd_lo,
  output logic [63:0]      rd_hi,
  input  wire splr_vwr_t   wr
);

  logic [63:0] lo_r [32];
  logic [63:0] hi_r [32];

  assign rd_lo = lo_r[rd_idx];
  assign rd_hi = hi_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) begin
        lo_r[i] <= '0;
        hi_r[i] <= '0;
      end
    end else begin
      if (wr.lo_we) begin
        lo_r[wr.idx] <= wr.lo;
      end
      if (wr.hi_we) begin
        hi_r[wr.idx] <= wr.hi;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/splr_exec.sv
`default_nettype none

module splr_exec
  import splr_pkg::*;
(
  input  wire logic [31:0] instr,
  input  wire logic [63:0] gv,
  input  wire logic [63:0] vlo,
  input  wire logic [63:0] vhi,
  output splr_res_t        res,
  output splr_vwr_t        wr
);

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'b000, b[k]};
    end
    return n;
  endfunction

  logic        sf, q, u, ext;
  logic [1:0]  ftype, rmode, size;
  logic [2:0]  opc;
  logic [4:0]  rn, rd, op5;
  logic        fmov_class, ftype_ok;
  logic        is_to_gpr, is_from_gpr, is_to_gpr_hi, is_from_gpr_hi;
  logic        is_cnt, is_addlv, is_addv;
  logic [127:0] v;

  logic [11:0] sb;
  logic [18:0] sh;
  logic [33:0] sw;
  logic [63:0] sd;
  logic [63:0] addlv_val, addv_val, cnt_lo, cnt_hi;

  assign sf    = instr[31];
  assign q     = instr[30];
  assign u     = instr[29];
  assign size  = instr[23:22];
  assign ftype = instr[23:22];
  assign rmode = instr[20:19];
  assign opc   = instr[18:16];
  assign op5   = instr[16:12];
  assign rn    = instr[9:5];
  assign rd    = instr[4:0];
  assign ext   = ~u;

  assign fmov_class = (instr[28:24] == FMOV_CLASS) && (instr[30:29] == FMOV_SCALAR)
                      && instr[21] && (instr[15:10] == FMOV_ZERO_OP);
  assign ftype_ok   = (!sf && ftype == FTYPE_S) || (sf && ftype == FTYPE_D);

  assign is_to_gpr      = fmov_class && opc == OPC_TO_GPR && rmode == RMODE_LOW && ftype_ok;
  assign is_from_gpr    = fmov_class && opc == OPC_FROM_GPR && rmode == RMODE_LOW && ftype_ok;
  assign is_to_gpr_hi   = fmov_class && opc == OPC_TO_GPR && rmode == RMODE_UPPER
                          && sf && ftype == FTYPE_Q;
  assign is_from_gpr_hi = fmov_class && opc == OPC_FROM_GPR && rmode == RMODE_UPPER
                          && sf && ftype == FTYPE_Q;

  assign is_cnt   = ((instr & ADVSIMD_MASK) == CNT_MATCH) && !u && size == SIZE_B
                    && op5 == OP5_CNT;
  assign is_addlv = ((instr & ADVSIMD_MASK) == ACROSS_MATCH) && op5 == OP5_ADDLV;
  assign is_addv  = ((instr & ADVSIMD_MASK) == ACROSS_MATCH) && op5 == OP5_ADDV && !u;

  // 64-bit form only looks at the low half
  assign v = {(q ? vhi : 64'd0), vlo};

  // Lane sums at each element size; byte, halfword and word sums add four group sums in two levels
  always_comb begin
    logic [11:0] bg [4];
    logic [18:0] hg [4];
    logic [33:0] wl [4];
    for (int g = 0; g < 4; g++) begin
      bg[g] = '0;
      for (int j = 0; j < 4; j++) begin
        bg[g] = bg[g] + {{4{ext & v[32*g + 8*j + 7]}}, v[32*g + 8*j +: 8]};
      end
      hg[g] = {{3{ext & v[32*g + 15]}}, v[32*g +: 16]}
            + {{3{ext & v[32*g + 31]}}, v[32*g + 16 +: 16]};
      wl[g] = {{2{ext & v[32*g + 31]}}, v[32*g +: 32]};
    end
    sb = (bg[0] + bg[1]) + (bg[2] + bg[3]);
    sh = (hg[0] + hg[1]) + (hg[2] + hg[3]);
    sw = (wl[0] + wl[1]) + (wl[2] + wl[3]);
    sd = v[63:0] + v[127:64];
  end

  always_comb begin
    case (size)
      SIZE_B: begin
        addlv_val = {48'd0, {4{ext & sb[11]}}, sb};
        addv_val  = {56'd0, sb[7:0]};
      end
      SIZE_H: begin
        addlv_val = {32'd0, {13{ext & sh[18]}}, sh};
        addv_val  = {48'd0, sh[15:0]};
      end
      SIZE_S: begin
        addlv_val = {{30{ext & sw[33]}}, sw};
        addv_val  = {32'd0, sw[31:0]};
      end
      SIZE_D: begin
        addlv_val = sd;
        addv_val  = sd;
      end
      default: begin
        addlv_val = '0;
        addv_val  = '0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cnt_lo[8*i +: 8] = {4'b0000, pop8(v[8*i +: 8])};
      cnt_hi[8*i +: 8] = {4'b0000, pop8(v[64 + 8*i +: 8])};
    end
  end

  always_comb begin
    res = '0;
    wr  = '0;
    wr.idx = rd;
    if (is_to_gpr) begin
      res.gpr_write = 1'b1;
      res.gpr_index = rd;
      res.gpr_data  = sf ? vlo : {32'd0, vlo[31:0]};
    end else if (is_from_gpr) begin
      wr.lo_we = 1'b1;
      wr.hi_we = 1'b1;
      wr.lo    = sf ? gv : {32'd0, gv[31:0]};
    end else if (is_to_gpr_hi) begin
      res.gpr_write = 1'b1;
      res.gpr_index = rd;
      res.gpr_data  = vhi;
    end else if (is_from_gpr_hi) begin
      wr.hi_we = 1'b1;
      wr.hi    = gv;
    end else if (is_cnt) begin
      wr.lo_we = 1'b1;
      wr.hi_we = 1'b1;
      wr.lo    = cnt_lo;
      wr.hi    = cnt_hi;
    end else if (is_addlv) begin
      wr.lo_we = 1'b1;
      wr.hi_we = 1'b1;
      wr.lo    = addlv_val;
    end else if (is_addv) begin
      wr.lo_we = 1'b1;
      wr.hi_we = 1'b1;
      wr.lo    = addv_val;
    end else begin
      res.undefined_insn = 1'b1;
    end
  end

endmodule

`default_nettype wire
